// File: rtl/sat_pkg.sv
// sat_pkg: shared types and constants for the sorted array table
// holds sizes, operation and status codes, sequencer states and the
// structs passed between the sequencer, the entry memory and the compare unit
package sat_pkg;

   localparam int DEPTH       = 64;
   localparam int DATA_WIDTH  = 32;
   localparam int ADDR_WIDTH  = $clog2(DEPTH);
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      MODE_INSERT = 3'd0,
      MODE_POP    = 3'd1,
      MODE_REMOVE = 3'd2,
      MODE_SEARCH = 3'd3,
      MODE_READ   = 3'd4,
      MODE_CLEAR  = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_FULL     = 3'd1,
      STATUS_EMPTY    = 3'd2,
      STATUS_RANGE    = 3'd3,
      STATUS_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_INS_SCAN,
      SEQ_REM_SHIFT,
      SEQ_SRCH_RD,
      SEQ_SRCH_CMP,
      SEQ_READ_RD,
      SEQ_READ_WAIT,
      SEQ_RESULT
   } seq_state_type;

   typedef struct packed {
      logic                         rd_en;
      logic [ADDR_WIDTH-1:0]        rd_addr;
      logic                         wr_en;
      logic [ADDR_WIDTH-1:0]        wr_addr;
      logic signed [DATA_WIDTH-1:0] wr_data;
   } mem_req_type;

   typedef struct packed {
      logic lt;
      logic eq;
      logic gt;
   } cmp_res_type;

   typedef struct packed {
      status_type                   status;
      logic [ADDR_WIDTH-1:0]        found_index;
      logic signed [DATA_WIDTH-1:0] read_value;
      logic [COUNT_WIDTH-1:0]       fill_count;
   } result_type;

endpackage

// File: rtl/sat_mem.sv
// sat_mem: entry storage, one write port and one read port
// read data is registered; uses sat_pkg for sizes and the request struct
module sat_mem (
   input  logic                                  clock,
   input  sat_pkg::mem_req_type                  req,
   output logic signed [sat_pkg::DATA_WIDTH-1:0] rd_data
);

   logic signed [sat_pkg::DATA_WIDTH-1:0] mem [sat_pkg::DEPTH];

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data <= mem[req.rd_addr];
      end
   end

endmodule

// File: rtl/sat_cmp.sv
// sat_cmp: shared signed compare of a stored entry against the key
// uses sat_pkg for the data width and the result struct
module sat_cmp (
   input  logic signed [sat_pkg::DATA_WIDTH-1:0] entry,
   input  logic signed [sat_pkg::DATA_WIDTH-1:0] key,
   output sat_pkg::cmp_res_type                  res
);

   always_comb begin
      res.lt = entry < key;
      res.eq = entry == key;
      res.gt = !res.lt && !res.eq;
   end

endmodule

// File: rtl/sat_seq.sv
// sat_seq: operation sequencer, entry count and result assembly
// drives sat_mem through a request struct and reads the sat_cmp result; uses sat_pkg
module sat_seq (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [2:0]                            req_mode,
   input  logic signed [sat_pkg::DATA_WIDTH-1:0] req_value,
   input  logic [sat_pkg::ADDR_WIDTH-1:0]        req_position,
   output sat_pkg::mem_req_type                  mem_req,
   input  logic signed [sat_pkg::DATA_WIDTH-1:0] mem_rd_data,
   output logic signed [sat_pkg::DATA_WIDTH-1:0] cmp_key,
   input  sat_pkg::cmp_res_type                  cmp_res,
   output logic                                  res_valid,
   input  logic                                  res_ready,
   output sat_pkg::result_type                   res
);

   localparam int AW = sat_pkg::ADDR_WIDTH;
   localparam int CW = sat_pkg::COUNT_WIDTH;

   sat_pkg::seq_state_type state_ff, state_in;
   logic [CW-1:0]                         count_ff, count_in;
   logic signed [sat_pkg::DATA_WIDTH-1:0] value_ff, value_in;
   logic [AW-1:0]                         pos_ff, pos_in;
   logic [CW-1:0]                         ptr_ff, ptr_in;
   logic                                  vld_ff, vld_in;
   logic signed [CW:0]                    lo_ff, lo_in, hi_ff, hi_in;
   logic [AW-1:0]                         mid_ff, mid_in;
   sat_pkg::status_type                   status_ff, status_in;
   logic [AW-1:0]                         fidx_ff, fidx_in;
   logic signed [sat_pkg::DATA_WIDTH-1:0] rval_ff, rval_in;

   logic          accept;
   logic          ins_more, ins_done, ins_rd;
   logic [CW-1:0] ins_wr_addr;
   logic          rem_more, rem_done;
   logic [CW-1:0] rem_wr_addr;
   logic          srch_done;
   logic [AW:0]   mid_sum;
   logic          pos_bad;

   assign accept = req_valid && req_ready;

   // insert walks down from the top entry; ptr below zero means no more entries
   assign ins_more    = !ptr_ff[CW-1];
   assign ins_rd      = ins_more && (!vld_ff || cmp_res.gt);
   assign ins_done    = (vld_ff && !cmp_res.gt) || (!vld_ff && !ins_more);
   assign ins_wr_addr = vld_ff ? ptr_ff + CW'(2) : ptr_ff + CW'(1);

   // remove walks up, moving each later entry one place down
   assign rem_more    = ptr_ff < count_ff;
   assign rem_done    = !vld_ff && !rem_more;
   assign rem_wr_addr = ptr_ff - CW'(2);

   assign srch_done = lo_ff > hi_ff;
   assign mid_sum   = {1'b0, lo_ff[AW-1:0]} + {1'b0, hi_ff[AW-1:0]};
   assign pos_bad   = CW'(req_position) >= count_ff;

   assign cmp_key = value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sat_pkg::SEQ_IDLE;
         count_ff <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      pos_ff    <= pos_in;
      ptr_ff    <= ptr_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      status_ff <= status_in;
      fidx_ff   <= fidx_in;
      rval_ff   <= rval_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sat_pkg::SEQ_IDLE: begin
            if (accept) begin
               case (sat_pkg::mode_type'(req_mode))
                  sat_pkg::MODE_INSERT: begin
                     state_in = (count_ff == CW'(sat_pkg::DEPTH)) ?
                                sat_pkg::SEQ_RESULT : sat_pkg::SEQ_INS_SCAN;
                  end
                  sat_pkg::MODE_REMOVE: begin
                     state_in = pos_bad ? sat_pkg::SEQ_RESULT : sat_pkg::SEQ_REM_SHIFT;
                  end
                  sat_pkg::MODE_SEARCH: state_in = sat_pkg::SEQ_SRCH_RD;
                  sat_pkg::MODE_READ: begin
                     state_in = pos_bad ? sat_pkg::SEQ_RESULT : sat_pkg::SEQ_READ_RD;
                  end
                  default: state_in = sat_pkg::SEQ_RESULT;
               endcase
            end
         end
         sat_pkg::SEQ_INS_SCAN: if (ins_done) state_in = sat_pkg::SEQ_RESULT;
         sat_pkg::SEQ_REM_SHIFT: if (rem_done) state_in = sat_pkg::SEQ_RESULT;
         sat_pkg::SEQ_SRCH_RD: begin
            state_in = srch_done ? sat_pkg::SEQ_RESULT : sat_pkg::SEQ_SRCH_CMP;
         end
         sat_pkg::SEQ_SRCH_CMP: begin
            state_in = cmp_res.eq ? sat_pkg::SEQ_RESULT : sat_pkg::SEQ_SRCH_RD;
         end
         sat_pkg::SEQ_READ_RD:   state_in = sat_pkg::SEQ_READ_WAIT;
         sat_pkg::SEQ_READ_WAIT: state_in = sat_pkg::SEQ_RESULT;
         sat_pkg::SEQ_RESULT:    if (res_ready) state_in = sat_pkg::SEQ_IDLE;
         default:                state_in = sat_pkg::SEQ_IDLE;
      endcase
   end

   // outputs: handshakes and memory port
   always_comb begin
      req_ready       = state_ff == sat_pkg::SEQ_IDLE;
      res_valid       = state_ff == sat_pkg::SEQ_RESULT;
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = ptr_ff[AW-1:0];
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = ins_wr_addr[AW-1:0];
      mem_req.wr_data = value_ff;
      case (state_ff)
         sat_pkg::SEQ_INS_SCAN: begin
            mem_req.rd_en   = ins_rd;
            mem_req.wr_en   = vld_ff || !ins_more;
            mem_req.wr_data = (vld_ff && cmp_res.gt) ? mem_rd_data : value_ff;
         end
         sat_pkg::SEQ_REM_SHIFT: begin
            mem_req.rd_en   = rem_more;
            mem_req.wr_en   = vld_ff;
            mem_req.wr_addr = rem_wr_addr[AW-1:0];
            mem_req.wr_data = mem_rd_data;
         end
         sat_pkg::SEQ_SRCH_RD: begin
            mem_req.rd_en   = !srch_done;
            mem_req.rd_addr = mid_sum[AW:1];
         end
         sat_pkg::SEQ_READ_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = pos_ff;
         end
         default: ;
      endcase
   end

   // datapath registers
   always_comb begin
      count_in  = count_ff;
      value_in  = value_ff;
      pos_in    = pos_ff;
      ptr_in    = ptr_ff;
      vld_in    = vld_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      status_in = status_ff;
      fidx_in   = fidx_ff;
      rval_in   = rval_ff;
      case (state_ff)
         sat_pkg::SEQ_IDLE: begin
            if (accept) begin
               value_in  = req_value;
               pos_in    = req_position;
               vld_in    = 1'b0;
               status_in = sat_pkg::STATUS_OK;
               fidx_in   = '0;
               rval_in   = '0;
               lo_in     = '0;
               hi_in     = $signed({1'b0, count_ff}) - (CW+1)'(1);
               case (sat_pkg::mode_type'(req_mode))
                  sat_pkg::MODE_INSERT: begin
                     ptr_in = count_ff - CW'(1);
                     if (count_ff == CW'(sat_pkg::DEPTH)) begin
                        status_in = sat_pkg::STATUS_FULL;
                     end
                  end
                  sat_pkg::MODE_POP: begin
                     if (count_ff == '0) begin
                        status_in = sat_pkg::STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  sat_pkg::MODE_REMOVE: begin
                     ptr_in = CW'(req_position) + CW'(1);
                     if (pos_bad) status_in = sat_pkg::STATUS_RANGE;
                  end
                  sat_pkg::MODE_READ: begin
                     if (pos_bad) status_in = sat_pkg::STATUS_RANGE;
                  end
                  sat_pkg::MODE_CLEAR: count_in = '0;
                  default: ;
               endcase
            end
         end
         sat_pkg::SEQ_INS_SCAN: begin
            vld_in = ins_rd;
            if (ins_rd) ptr_in = ptr_ff - CW'(1);
            if (ins_done) begin
               fidx_in  = ins_wr_addr[AW-1:0];
               count_in = count_ff + CW'(1);
            end
         end
         sat_pkg::SEQ_REM_SHIFT: begin
            vld_in = rem_more;
            if (rem_more) ptr_in = ptr_ff + CW'(1);
            if (rem_done) count_in = count_ff - CW'(1);
         end
         sat_pkg::SEQ_SRCH_RD: begin
            mid_in = mid_sum[AW:1];
            if (srch_done) status_in = sat_pkg::STATUS_NOTFOUND;
         end
         sat_pkg::SEQ_SRCH_CMP: begin
            if (cmp_res.eq) begin
               fidx_in = mid_ff;
            end else if (cmp_res.lt) begin
               lo_in = $signed({2'b00, mid_ff}) + (CW+1)'(1);
            end else begin
               hi_in = $signed({2'b00, mid_ff}) - (CW+1)'(1);
            end
         end
         sat_pkg::SEQ_READ_WAIT: rval_in = mem_rd_data;
         default: ;
      endcase
   end

   assign res.status      = status_ff;
   assign res.found_index = fidx_ff;
   assign res.read_value  = rval_ff;
   assign res.fill_count  = count_ff;

endmodule

// File: rtl/sorted_array_table.sv
// sorted_array_table: fixed-capacity table of signed entries kept in ascending order
// top level; instantiates sat_seq, sat_mem and sat_cmp, uses sat_pkg
//
// usage
//  - req channel: one operation per transfer (mode, value, position); modes are
//    insert, pop, remove at index, search, read at index and clear
//  - rsp channel: one result per operation (status, found_index, read_value,
//    fill_count), held in an output register until the transfer completes
//  - req_ready is high only while the sequencer is idle; one operation at a time
//  - the time from req transfer to rsp transfer depends on the operation and is
//    set by the single read port and the shared compare unit:
//      insert   walks down from the top, one entry per cycle
//      remove   moves one entry per cycle, from position up to fill_count
//      search   up to 7 binary probes, each a read state then a compare state
//      read     a read state then a wait state; pop, clear and failed checks go straight to the result
//  - a new request can be taken as soon as the result enters the output
//    register, even while rsp_ready is low; a second finished result waits
//    in the sequencer until the output register frees
//  - reset (synchronous, active high) empties the table and drops any pending
//    result; the entry memory itself is not cleared, only the count
module sorted_array_table (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [2:0]                            req_mode,
   input  logic signed [sat_pkg::DATA_WIDTH-1:0] req_value,
   input  logic [sat_pkg::ADDR_WIDTH-1:0]        req_position,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [2:0]                            rsp_status,
   output logic [sat_pkg::ADDR_WIDTH-1:0]        rsp_found_index,
   output logic signed [sat_pkg::DATA_WIDTH-1:0] rsp_read_value,
   output logic [sat_pkg::COUNT_WIDTH-1:0]       rsp_fill_count
);

   sat_pkg::mem_req_type                  mem_req;
   logic signed [sat_pkg::DATA_WIDTH-1:0] mem_rd_data;
   logic signed [sat_pkg::DATA_WIDTH-1:0] cmp_key;
   sat_pkg::cmp_res_type                  cmp_res;
   logic                                  res_valid;
   logic                                  out_free;
   sat_pkg::result_type                   res;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   sat_pkg::result_type rsp_data_ff, rsp_data_in;

   // sequencer owns the count and drives the memory and compare unit
   sat_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_value    (req_value),
      .req_position (req_position),
      .mem_req      (mem_req),
      .mem_rd_data  (mem_rd_data),
      .cmp_key      (cmp_key),
      .cmp_res      (cmp_res),
      .res_valid    (res_valid),
      .res_ready    (out_free),
      .res          (res)
   );

   sat_mem u_mem (
      .clock   (clock),
      .req     (mem_req),
      .rd_data (mem_rd_data)
   );

   // one compare serves both the insert walk and the binary search
   sat_cmp u_cmp (
      .entry (mem_rd_data),
      .key   (cmp_key),
      .res   (cmp_res)
   );

   // slot frees when empty or when its transfer completes this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = res_valid;
         if (res_valid) rsp_data_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_data_ff.status;
   assign rsp_found_index = rsp_data_ff.found_index;
   assign rsp_read_value  = rsp_data_ff.read_value;
   assign rsp_fill_count  = rsp_data_ff.fill_count;

endmodule

// File: dv/sorted_array_table_checker.sv
`timescale 1ns / 1ps
// sorted_array_table_checker: watches both channels of the sorted array table,
// predicts each result from its own copy of the table and compares field by field
// depends on sat_pkg for sizes, operation and status codes and the result struct
module sorted_array_table_checker
   import sat_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [2:0]                   req_mode,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  logic [ADDR_WIDTH-1:0]        req_position,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [2:0]                   rsp_status,
   input  logic [ADDR_WIDTH-1:0]        rsp_found_index,
   input  logic signed [DATA_WIDTH-1:0] rsp_read_value,
   input  logic [COUNT_WIDTH-1:0]       rsp_fill_count,
   output int                           results_owed,
   output int                           mismatch_count
);

   logic signed [DATA_WIDTH-1:0] table_entries [DEPTH];
   int                           table_fill;
   result_type                   owed_results [$];

   // carries out one operation on the shadow table and returns its result
   function automatic result_type apply_table_op(input logic [2:0] op,
                                                 input logic signed [DATA_WIDTH-1:0] value,
                                                 input logic [ADDR_WIDTH-1:0] slot);
      result_type outcome;
      int         idx;
      int         k;
      int         lo;
      int         hi;
      int         mid;
      outcome.status      = STATUS_OK;
      outcome.found_index = '0;
      outcome.read_value  = '0;
      case (op)
         MODE_INSERT: begin
            if (table_fill >= DEPTH) begin
               outcome.status = STATUS_FULL;
            end else begin
               // lands after any equal entries
               idx = 0;
               while (idx < table_fill && table_entries[idx] <= value) idx++;
               for (k = table_fill; k > idx; k--) table_entries[k] = table_entries[k-1];
               table_entries[idx]  = value;
               table_fill++;
               outcome.found_index = ADDR_WIDTH'(idx);
            end
         end
         MODE_POP: begin
            if (table_fill == 0) outcome.status = STATUS_EMPTY;
            else table_fill--;
         end
         MODE_REMOVE: begin
            if (int'(slot) >= table_fill) begin
               outcome.status = STATUS_RANGE;
            end else begin
               for (k = int'(slot); k + 1 < table_fill; k++) begin
                  table_entries[k] = table_entries[k+1];
               end
               table_fill--;
            end
         end
         MODE_SEARCH: begin
            outcome.status = STATUS_NOTFOUND;
            lo = 0;
            hi = table_fill - 1;
            while (lo <= hi) begin
               mid = (lo + hi) / 2;
               if (table_entries[mid] == value) begin
                  outcome.status      = STATUS_OK;
                  outcome.found_index = ADDR_WIDTH'(mid);
                  break;
               end
               if (table_entries[mid] < value) lo = mid + 1;
               else hi = mid - 1;
            end
         end
         MODE_READ: begin
            if (int'(slot) >= table_fill) outcome.status = STATUS_RANGE;
            else outcome.read_value = table_entries[slot];
         end
         MODE_CLEAR: begin
            table_fill = 0;
         end
         default: begin
         end
      endcase
      outcome.fill_count = COUNT_WIDTH'(table_fill);
      return outcome;
   endfunction

   always @(posedge clock) begin
      result_type owed;
      if (reset) begin
         table_fill = 0;
         owed_results.delete();
         results_owed <= 0;
      end else begin
         // compare before predicting: a result never belongs to a same-edge request
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               $error("result transfer with no result owed");
               mismatch_count++;
            end else begin
               owed = owed_results.pop_front();
               if (rsp_status !== owed.status) begin
                  $error("status: expected %0d, got %0d", owed.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_found_index !== owed.found_index) begin
                  $error("found_index: expected %0d, got %0d", owed.found_index,
                         rsp_found_index);
                  mismatch_count++;
               end
               if (rsp_read_value !== owed.read_value) begin
                  $error("read_value: expected %0d, got %0d", owed.read_value,
                         rsp_read_value);
                  mismatch_count++;
               end
               if (rsp_fill_count !== owed.fill_count) begin
                  $error("fill_count: expected %0d, got %0d", owed.fill_count,
                         rsp_fill_count);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            owed_results.push_back(apply_table_op(req_mode, req_value, req_position));
         end
         results_owed <= owed_results.size();
      end
   end

endmodule

// File: dv/sorted_array_table_tb.sv
`timescale 1ns / 1ps
// sorted_array_table_tb: top of the sorted array table testbench; drives requests,
// drains results with random stalls and reports the verdict
// depends on sat_pkg, sorted_array_table and sorted_array_table_checker
module sorted_array_table_tb;
   import sat_pkg::*;

   // mode codes the block treats as no-ops
   localparam logic [2:0] MODE_SPARE_LO = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   // flavors of random episode
   localparam int BIAS_FILL  = 0;
   localparam int BIAS_DRAIN = 1;
   localparam int BIAS_MIXED = 2;
   localparam int BIAS_NOISE = 3;

   localparam int RANDOM_ITEMS = 1525;
   // longest latency is an insert into a nearly full table, plus margin
   localparam int TAIL_CYCLES  = 80;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [2:0]                   req_mode = MODE_INSERT;
   logic signed [DATA_WIDTH-1:0] req_value = '0;
   logic [ADDR_WIDTH-1:0]        req_position = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [2:0]                   rsp_status;
   logic [ADDR_WIDTH-1:0]        rsp_found_index;
   logic signed [DATA_WIDTH-1:0] rsp_read_value;
   logic [COUNT_WIDTH-1:0]       rsp_fill_count;

   int results_owed;
   int mismatch_count;

   // when set, neither side idles (back-to-back stretches)
   bit calm = 1'b0;
   int sent_by_mode [8];

   // 4 ns clock
   always #2 clock = ~clock;

   sorted_array_table i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_read_value  (rsp_read_value),
      .rsp_fill_count  (rsp_fill_count)
   );

   sorted_array_table_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_read_value  (rsp_read_value),
      .rsp_fill_count  (rsp_fill_count),
      .results_owed    (results_owed),
      .mismatch_count  (mismatch_count)
   );

   // one request transfer; valid stays high after the transfer so that a
   // zero gap gives back-to-back requests without dropping valid
   task automatic send_op(input logic [2:0] op, input logic signed [DATA_WIDTH-1:0] value,
                          input logic [ADDR_WIDTH-1:0] slot);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= op;
      req_value    <= value;
      req_position <= slot;
      do @(posedge clock); while (!req_ready);
      sent_by_mode[op]++;
   endtask

   // hold off the sender until every owed result has been transferred
   task automatic wait_drained();
      req_valid <= 1'b0;
      // let the checker count the last request first
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
   endtask

   // operation mix per episode flavor
   function automatic logic [2:0] pick_op(input int bias);
      int roll;
      roll = $urandom_range(0, 99);
      case (bias)
         BIAS_FILL: begin
            if (roll < 85) return MODE_INSERT;
            if (roll < 88) return MODE_POP;
            if (roll < 94) return MODE_SEARCH;
            return MODE_READ;
         end
         BIAS_DRAIN: begin
            if (roll < 15) return MODE_INSERT;
            if (roll < 50) return MODE_POP;
            if (roll < 75) return MODE_REMOVE;
            if (roll < 85) return MODE_SEARCH;
            if (roll < 97) return MODE_READ;
         end
         BIAS_MIXED: begin
            if (roll < 35) return MODE_INSERT;
            if (roll < 45) return MODE_POP;
            if (roll < 55) return MODE_REMOVE;
            if (roll < 75) return MODE_SEARCH;
            if (roll < 95) return MODE_READ;
            if (roll < 98) return MODE_CLEAR;
         end
         default: begin
            if (roll < 25) return MODE_INSERT;
            if (roll < 35) return MODE_POP;
            if (roll < 45) return MODE_REMOVE;
            if (roll < 60) return MODE_SEARCH;
            if (roll < 75) return MODE_READ;
            if (roll < 85) return MODE_CLEAR;
         end
      endcase
      return $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
   endfunction

   // small values give duplicates and search hits, the rest spans the full range
   function automatic logic signed [DATA_WIDTH-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4) return int'($urandom_range(0, 31)) - 16;
      if (roll < 6) begin
         case ($urandom_range(0, 3))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            default: return -1;
         endcase
      end
      return $urandom;
   endfunction

   // bias toward low slots so remove and read often land inside the table
   function automatic logic [ADDR_WIDTH-1:0] pick_position();
      if ($urandom_range(0, 1)) return ADDR_WIDTH'($urandom_range(0, 63));
      return ADDR_WIDTH'($urandom_range(0, 15));
   endfunction

   // result side: random stall per result, ready held high through zero stalls
   initial begin : rsp_drain
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin : stimulus
      int sent_total;
      int episode_len;
      int bias;
      int n;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table: the failing pop, remove, read and search paths
      send_op(MODE_POP, '0, '0);
      send_op(MODE_REMOVE, '0, '0);
      send_op(MODE_READ, '0, '0);
      send_op(MODE_SEARCH, '0, '0);
      // extremes and a duplicate
      send_op(MODE_INSERT, 32'sd5, '0);
      send_op(MODE_INSERT, 32'sh7fff_ffff, '0);
      send_op(MODE_INSERT, 32'sh8000_0000, '0);
      send_op(MODE_INSERT, 32'sd5, '0);
      send_op(MODE_INSERT, '0, '0);
      send_op(MODE_INSERT, -32'sd1, '0);
      // duplicate key, missing key, both ends
      send_op(MODE_SEARCH, 32'sd5, '0);
      send_op(MODE_SEARCH, 32'sd7, '0);
      send_op(MODE_SEARCH, 32'sh7fff_ffff, '0);
      send_op(MODE_READ, '0, 6'd0);
      send_op(MODE_READ, '0, 6'd5);
      send_op(MODE_READ, '0, 6'd63);
      // index equal to count is out of range
      send_op(MODE_REMOVE, '0, 6'd6);
      send_op(MODE_REMOVE, '0, 6'd1);
      send_op(MODE_POP, '0, '0);
      send_op(MODE_SPARE_LO, 32'sh7fff_ffff, 6'd63);
      send_op(MODE_SPARE_HI, -32'sd1, 6'd63);
      send_op(MODE_SEARCH, 32'sh8000_0000, '0);
      send_op(MODE_CLEAR, '0, '0);
      send_op(MODE_POP, '0, '0);
      send_op(MODE_READ, '0, 6'd0);

      // let the directed part settle before the random episodes
      wait_drained();

      sent_total = 0;
      while (sent_total < RANDOM_ITEMS) begin
         bias = $urandom_range(BIAS_FILL, BIAS_NOISE);
         calm = ($urandom_range(0, 3) == 0);
         episode_len = (bias == BIAS_FILL) ? $urandom_range(60, 140) : $urandom_range(15, 80);
         if ($urandom_range(0, 4) == 0) wait_drained();
         for (n = 0; n < episode_len && sent_total < RANDOM_ITEMS; n++) begin
            send_op(pick_op(bias), pick_value(), pick_position());
            sent_total++;
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d insert, %0d pop, %0d remove, %0d search, %0d read, %0d clear",
               sent_by_mode[MODE_INSERT], sent_by_mode[MODE_POP], sent_by_mode[MODE_REMOVE],
               sent_by_mode[MODE_SEARCH], sent_by_mode[MODE_READ], sent_by_mode[MODE_CLEAR]);
      $display("plus %0d unused-mode transfers, with random gaps and stalls on both channels",
               sent_by_mode[MODE_SPARE_LO] + sent_by_mode[MODE_SPARE_HI]);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin : run_limit
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// File: files.f
rtl/sat_pkg.sv
rtl/sat_mem.sv
rtl/sat_cmp.sv
rtl/sat_seq.sv
rtl/sorted_array_table.sv
dv/sorted_array_table_checker.sv
dv/sorted_array_table_tb.sv
